### rtl/poi_pkg.sv
// Package for the planar odometry integrator: types, constants, CORDIC angle table.
// No dependencies.
package poi_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;
  localparam int STEP_W       = 5;
  localparam int NUM_STEPS    = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [31:0]        RAD_TO_BAM  = 32'd2734261102;

  localparam logic signed [31:0] START_X_RST = 32'sd65536;
  localparam logic signed [31:0] START_Y_RST = 32'sd98304;
  localparam logic signed [31:0] START_H_RST = 32'sd0;

  typedef logic signed [33:0] cord_t;

  typedef enum logic [1:0] {
    REG_START_X = 2'd0,
    REG_START_Y = 2'd1,
    REG_START_H = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_COR1, ST_MULV, ST_MULT, ST_MULH, ST_UPD, ST_HALF, ST_COR2, ST_OUT
  } state_e;

  typedef struct packed {
    logic              start;
    logic signed [31:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic  done;
    cord_t cos_v;
    cord_t sin_v;
  } cordic_rsp_t;

  function automatic logic [31:0] atan_bam(input logic [STEP_W-1:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // Q2.30 to Q1.15, round half up, saturate
  function automatic logic signed [15:0] to_q15(input cord_t v);
    logic signed [34:0] s;
    logic signed [19:0] r;
    logic signed [15:0] o;
    s = 35'(v) + 35'sd16384;
    r = s[34:15];
    if (r > 20'sd32767)       o = 16'sh7FFF;
    else if (r < -20'sd32768) o = 16'sh8000;
    else                      o = r[15:0];
    return o;
  endfunction

endpackage

### rtl/poi_if.sv
// Valid/ready stream interfaces for odometry ticks and pose results.
// No dependencies.
interface poi_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] speed_forward;
  logic signed [15:0] speed_sideways;
  logic signed [15:0] yaw_rate;
  logic        [15:0] elapsed_time;
  modport source (output valid, speed_forward, speed_sideways, yaw_rate, elapsed_time,
                  input ready);
  modport sink   (input valid, speed_forward, speed_sideways, yaw_rate, elapsed_time,
                  output ready);
endinterface

interface poi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic signed [31:0] pose_heading;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;
  modport source (output valid, pose_x, pose_y, pose_heading, quat_z, quat_w,
                  input ready);
  modport sink   (input valid, pose_x, pose_y, pose_heading, quat_z, quat_w,
                  output ready);
endinterface

### rtl/poi_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, Q2.30 results.
// Depends on poi_pkg.
module poi_cordic (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  poi_pkg::cordic_req_t req_i,
  output poi_pkg::cordic_rsp_t rsp_o
);
  import poi_pkg::*;

  cord_t             x_q, y_q, z_q;
  logic              neg_q, run_q, done_q;
  logic [STEP_W-1:0] step_q;
  cord_t             az, xs, ys, at;

  assign az = 34'(req_i.angle);
  assign xs = x_q >>> step_q;
  assign ys = y_q >>> step_q;
  assign at = cord_t'({2'b00, atan_bam(step_q)});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(NUM_STEPS - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q <= CORDIC_GAIN;
      y_q <= '0;
      if (az > 34'sd1073741824) begin
        z_q   <= az - 34'sd2147483648;
        neg_q <= 1'b1;
      end else if (az < -34'sd1073741824) begin
        z_q   <= az + 34'sd2147483648;
        neg_q <= 1'b1;
      end else begin
        z_q   <= az;
        neg_q <= 1'b0;
      end
    end else if (run_q) begin
      if (!z_q[33]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.cos_v = neg_q ? -x_q : x_q;
  assign rsp_o.sin_v = neg_q ? -y_q : y_q;

endmodule

### rtl/planar_odometry_integrator_top.sv
// Channel   Dir  Transfer when          Payload
// in_i      in   valid & ready          speed_forward, speed_sideways, yaw_rate, elapsed_time
// out_o     out  valid & ready          pose_x, pose_y, pose_heading, quat_z, quat_w
// cfg       in   cfg_we_i               cfg_idx_i, cfg_data_i
// A tick runs from input transfer to result through two passes of the shared CORDIC
// plus bit-serial multiplies for the velocity, elapsed-time and heading products.
// One tick in flight; the next input is taken while the result register waits.
// Reset loads the pose state with the start defaults.
// Top level of the odometry integrator; depends on poi_pkg, poi_if, poi_cordic.
module planar_odometry_integrator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  poi_in_if.sink      in_i,
  poi_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import poi_pkg::*;

  state_e state_q, state_d;
  logic [STEP_W-1:0] cnt_q;

  logic signed [31:0] pos_x_q, pos_y_q, head_q;

  logic signed [15:0] vf_q, vs_q;
  logic signed [31:0] wm_q;
  logic        [15:0] dt_q;
  logic signed [49:0] mc_q, ms_q, ax_q, ay_q;
  logic signed [65:0] axm_q, aym_q, rx_q, ry_q;
  logic signed [31:0] wdt_q, wsh_q;
  logic signed [63:0] rad_q, hacc_q;
  logic signed [15:0] qz_q, qw_q;

  logic               ovalid_q;
  logic signed [31:0] ox_q, oy_q, oh_q;
  logic signed [15:0] oz_q, ow_q;

  cordic_req_t creq;
  cordic_rsp_t crsp;

  logic in_fire, cnt_last16, cnt_last32, out_free;
  logic signed [49:0] tc, ts, tsc, tcs;
  logic signed [65:0] rxr, ryr;
  logic signed [63:0] hr;
  logic signed [32:0] nx, ny;

  poi_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (creq),
    .rsp_o  (crsp)
  );

  assign in_fire    = in_i.valid && in_i.ready;
  assign cnt_last16 = (cnt_q == STEP_W'(15));
  assign cnt_last32 = (cnt_q == STEP_W'(31));
  assign out_free   = !ovalid_q || out_o.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_COR1;
      ST_COR1: if (crsp.done) state_d = ST_MULV;
      ST_MULV: if (cnt_last16) state_d = ST_MULT;
      ST_MULT: if (cnt_last16) state_d = ST_MULH;
      ST_MULH: if (cnt_last32) state_d = ST_UPD;
      ST_UPD:  state_d = ST_HALF;
      ST_HALF: state_d = ST_COR2;
      ST_COR2: if (crsp.done) state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    creq.start = 1'b0;
    creq.angle = head_q;
    in_i.ready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        creq.start = in_fire;
      end
      ST_HALF: begin
        creq.start = 1'b1;
        creq.angle = head_q >>> 1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q != state_d) cnt_q <= '0;
      else                    cnt_q <= cnt_q + 1'b1;
    end
  end

  // serial products: one multiplier bit per cycle
  assign tc  = vf_q[0] ? mc_q : '0;
  assign ts  = vs_q[0] ? ms_q : '0;
  assign tsc = vf_q[0] ? ms_q : '0;
  assign tcs = vs_q[0] ? mc_q : '0;

  assign rxr = rx_q + 66'sh20000000000;
  assign ryr = ry_q + 66'sh20000000000;
  assign hr  = hacc_q + 64'sh20000000;
  assign nx  = 33'(pos_x_q) + 33'($signed(rxr[65:42]));
  assign ny  = 33'(pos_y_q) + 33'($signed(ryr[65:42]));

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        vf_q <= in_i.speed_forward;
        vs_q <= in_i.speed_sideways;
        wm_q <= 32'(in_i.yaw_rate);
        dt_q <= in_i.elapsed_time;
      end
      ST_COR1: begin
        mc_q <= 50'(crsp.cos_v);
        ms_q <= 50'(crsp.sin_v);
        ax_q <= '0;
        ay_q <= '0;
      end
      ST_MULV: begin
        if (cnt_last16) begin
          ax_q <= ax_q - tc + ts;
          ay_q <= ay_q - tsc - tcs;
          axm_q <= 66'(ax_q - tc + ts);
          aym_q <= 66'(ay_q - tsc - tcs);
          rx_q  <= '0;
          ry_q  <= '0;
          wdt_q <= '0;
        end else begin
          ax_q <= ax_q + tc - ts;
          ay_q <= ay_q + tsc + tcs;
        end
        mc_q <= mc_q <<< 1;
        ms_q <= ms_q <<< 1;
        vf_q <= vf_q >>> 1;
        vs_q <= vs_q >>> 1;
      end
      ST_MULT: begin
        if (dt_q[0]) begin
          rx_q  <= rx_q + axm_q;
          ry_q  <= ry_q + aym_q;
          wdt_q <= wdt_q + wm_q;
        end
        axm_q <= axm_q <<< 1;
        aym_q <= aym_q <<< 1;
        wm_q  <= wm_q <<< 1;
        dt_q  <= dt_q >> 1;
        if (cnt_last16) begin
          wsh_q  <= dt_q[0] ? wdt_q + wm_q : wdt_q;
          rad_q  <= 64'(RAD_TO_BAM);
          hacc_q <= '0;
        end
      end
      ST_MULH: begin
        if (wsh_q[0]) begin
          if (cnt_last32) hacc_q <= hacc_q - rad_q;
          else            hacc_q <= hacc_q + rad_q;
        end
        rad_q <= rad_q <<< 1;
        wsh_q <= wsh_q >>> 1;
      end
      ST_COR2: begin
        qz_q <= to_q15(crsp.sin_v);
        qw_q <= to_q15(crsp.cos_v);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= START_X_RST;
      pos_y_q   <= START_Y_RST;
      head_q    <= START_H_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_START_X: begin
          pos_x_q   <= cfg_data_i;
        end
        REG_START_Y: begin
          pos_y_q   <= cfg_data_i;
        end
        REG_START_H: begin
          head_q    <= cfg_data_i;
        end
        default: ;
      endcase
    end else if (state_q == ST_UPD) begin
      if (nx > 33'sh0_7FFFFFFF)       pos_x_q <= 32'sh7FFFFFFF;
      else if (nx < -33'sh0_80000000) pos_x_q <= 32'sh80000000;
      else                            pos_x_q <= nx[31:0];
      if (ny > 33'sh0_7FFFFFFF)       pos_y_q <= 32'sh7FFFFFFF;
      else if (ny < -33'sh0_80000000) pos_y_q <= 32'sh80000000;
      else                            pos_y_q <= ny[31:0];
      head_q <= head_q + hr[61:30];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (state_q == ST_OUT && out_free) begin
      ovalid_q <= 1'b1;
    end else if (out_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      ox_q <= pos_x_q;
      oy_q <= pos_y_q;
      oh_q <= head_q;
      oz_q <= qz_q;
      ow_q <= qw_q;
    end
  end

  assign out_o.valid        = ovalid_q;
  assign out_o.pose_x       = ox_q;
  assign out_o.pose_y       = oy_q;
  assign out_o.pose_heading = oh_q;
  assign out_o.quat_z       = oz_q;
  assign out_o.quat_w       = ow_q;

endmodule

### rtl/poi_checker.sv
// Port-level checks for the odometry integrator, bound to the top level.
// Depends on planar_odometry_integrator_top ports only.
module poi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pose_heading
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_pose_heading))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a tick is in flight");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("result appeared too soon after input transfer");

endmodule

bind planar_odometry_integrator_top poi_checker u_poi_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid         (in_i.valid),
  .in_ready         (in_i.ready),
  .out_valid        (out_o.valid),
  .out_ready        (out_o.ready),
  .out_pose_heading (out_o.pose_heading)
);

### sim/tb_top.sv
// Testbench for planar_odometry_integrator_top: streams odometry ticks through the
// block and checks every pose result against an in-bench fixed-point predictor.
// Depends on poi_pkg, poi_if and the RTL of the integrator.
module tb_top;
  import poi_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 150;

  typedef struct {
    logic signed [15:0] vf;
    logic signed [15:0] vs;
    logic signed [15:0] wr;
    logic        [15:0] dt;
  } tick_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] h;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
  } pose_t;

  localparam longint ATAN_TAB [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = REG_START_X;
  logic [31:0] cfg_data_i = '0;

  poi_in_if  in_if();
  poi_out_if out_if();

  planar_odometry_integrator_top u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_if.sink), .out_o(out_if.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  tick_t tick_q[$];
  pose_t pose_q[$];
  longint est_x = 65536, est_y = 98304;
  logic [31:0] est_h = '0;
  int errors = 0, n_ticks = 0, n_poses = 0, in_gap = 0, out_gap = 0, hold_cnt = 0;
  int idle_cnt = 0;
  bit in_fire = 0, out_fire = 0, idling_on = 1;

  function automatic void cordic_rotate(input longint ang, output longint c, output longint s);
    longint x, y, z, nx;
    bit neg;
    x = 652032874; y = 0; z = ang; neg = 0;
    if (z > (64'sd1 <<< 30)) begin
      z -= (64'sd1 <<< 31); neg = 1;
    end else if (z < -(64'sd1 <<< 30)) begin
      z += (64'sd1 <<< 31); neg = 1;
    end
    for (int i = 0; i < NUM_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= ATAN_TAB[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += ATAN_TAB[i];
      end
      x = nx;
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic logic signed [15:0] q30_to_q15(input longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic pose_t advance_pose(input tick_t t);
    longint vf, vs, wr, dt, c, s, rx, ry, dh;
    pose_t p;
    vf = longint'(t.vf); vs = longint'(t.vs); wr = longint'(t.wr);
    dt = longint'({48'd0, t.dt});
    cordic_rotate(longint'($signed(est_h)), c, s);
    rx = (vf * c - vs * s) * dt;
    ry = (vf * s + vs * c) * dt;
    est_x = clamp32(est_x + ((rx + (64'sd1 <<< 41)) >>> 42));
    est_y = clamp32(est_y + ((ry + (64'sd1 <<< 41)) >>> 42));
    dh = (wr * dt * 64'sd2734261102 + (64'sd1 <<< 29)) >>> 30;
    est_h = est_h + dh[31:0];
    cordic_rotate(longint'($signed(est_h)) >>> 1, c, s);
    p.x = est_x[31:0]; p.y = est_y[31:0]; p.h = est_h;
    p.qz = q30_to_q15(s); p.qw = q30_to_q15(c);
    return p;
  endfunction

  // sampling and checking
  always @(posedge clk_i) begin
    pose_t e;
    in_fire = in_if.valid && in_if.ready;
    out_fire = out_if.valid && out_if.ready;
    if (rst_ni) begin
      if (in_fire) begin
        tick_t t;
        t.vf = in_if.speed_forward; t.vs = in_if.speed_sideways;
        t.wr = in_if.yaw_rate; t.dt = in_if.elapsed_time;
        pose_q.push_back(advance_pose(t));
        n_ticks++;
      end
      if (out_fire) begin
        n_poses++;
        out_gap = idling_on ? $urandom_range(0, 3) : 0;
        if (pose_q.size() == 0) begin
          $error("result transfer with no expected pose");
          errors++;
        end else begin
          e = pose_q.pop_front();
          if (out_if.pose_x !== e.x) begin
            $error("pose_x exp %0d got %0d", e.x, out_if.pose_x); errors++;
          end
          if (out_if.pose_y !== e.y) begin
            $error("pose_y exp %0d got %0d", e.y, out_if.pose_y); errors++;
          end
          if (out_if.pose_heading !== e.h) begin
            $error("pose_heading exp %0d got %0d", e.h, out_if.pose_heading); errors++;
          end
          if (out_if.quat_z !== e.qz) begin
            $error("quat_z exp %0d got %0d", e.qz, out_if.quat_z); errors++;
          end
          if (out_if.quat_w !== e.qw) begin
            $error("quat_w exp %0d got %0d", e.qw, out_if.quat_w); errors++;
          end
        end
      end
      idle_cnt = (in_fire || out_fire || cfg_we_i) ? 0 : idle_cnt + 1;
      if (idle_cnt >= WATCHDOG_LIMIT) begin
        $display("timeout: %0d ticks sent, %0d poses left", n_ticks, pose_q.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // tick driver
  always @(negedge clk_i) begin
    tick_t t;
    if (rst_ni && (!in_if.valid || in_fire)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_if.valid <= 1'b0;
      end else if (tick_q.size() > 0) begin
        t = tick_q.pop_front();
        in_if.speed_forward <= t.vf; in_if.speed_sideways <= t.vs;
        in_if.yaw_rate <= t.wr; in_if.elapsed_time <= t.dt;
        in_if.valid <= 1'b1;
        in_gap = idling_on ? $urandom_range(0, 3) : 0;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result receiver, with optional long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_if.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    case (idx)
      REG_START_X: est_x = longint'($signed(val));
      REG_START_Y: est_y = longint'($signed(val));
      REG_START_H: est_h = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_tick(input logic [15:0] vf, vs, wr, dt);
    tick_t t;
    t.vf = vf; t.vs = vs; t.wr = wr; t.dt = dt;
    tick_q.push_back(t);
  endtask

  function automatic logic [15:0] rand_field();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 255)) - 16'd128;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_random(input int n);
    for (int i = 0; i < n; i++)
      add_tick(rand_field(), rand_field(), rand_field(),
               ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 64)) : rand_field());
  endtask

  task automatic drain();
    wait (tick_q.size() == 0 && !in_if.valid && pose_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    in_if.valid = 1'b0; in_if.speed_forward = '0; in_if.speed_sideways = '0;
    in_if.yaw_rate = '0; in_if.elapsed_time = '0; out_if.ready = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset pose, field extremes, heading wrap
    add_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add_tick(16'h7FFF, 16'h0000, 16'h0000, 16'hFFFF);
    add_tick(16'h8000, 16'h0000, 16'h0000, 16'hFFFF);
    add_tick(16'h0000, 16'h7FFF, 16'h0000, 16'hFFFF);
    add_tick(16'h0000, 16'h8000, 16'h0000, 16'hFFFF);
    add_tick(16'h0000, 16'h0000, 16'h7FFF, 16'hFFFF);
    add_tick(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
    add_tick(16'h0000, 16'h0000, 16'h8000, 16'hFFFF);
    add_tick(16'h8000, 16'h8000, 16'h8000, 16'hFFFF);
    add_tick(16'h1000, 16'h0000, 16'h3244, 16'h8000);
    add_tick(16'h1000, 16'hF000, 16'h3244, 16'h8000);
    add_tick(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000);
    add_tick(16'h0001, 16'hFFFF, 16'h0001, 16'h0001);
    add_tick(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    add_tick(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    drain();

    // start next to both ends of the position range, driving Y into saturation at the low end
    write_reg(REG_START_X, 32'h7FFF0000);
    write_reg(REG_START_Y, 32'h80010000);
    write_reg(REG_START_H, 32'h40000000);
    add_tick(16'h0000, 16'h7FFF, 16'h0000, 16'hFFFF);
    add_tick(16'h0000, 16'h7FFF, 16'h0000, 16'hFFFF);
    add_tick(16'h7FFF, 16'h0000, 16'h0000, 16'hFFFF);
    add_tick(16'h8000, 16'h0000, 16'h0000, 16'hFFFF);
    add_tick(16'h8000, 16'h0000, 16'h0000, 16'hFFFF);
    drain();

    write_reg(REG_UNUSED, 32'hFFFFFFFF);
    write_reg(REG_START_X, 32'h80000000);
    write_reg(REG_START_Y, 32'h7FFFFFFF);
    write_reg(REG_START_H, 32'h80000000);
    add_random(350);
    drain();

    // long receiver hold-off so the input side backs up
    write_reg(REG_START_X, 32'h00000000);
    write_reg(REG_START_Y, 32'h00000000);
    write_reg(REG_START_H, 32'h7FFFFFFF);
    idling_on = 0;
    hold_cnt = 600;
    add_random(350);
    drain();
    idling_on = 1;

    for (int ph = 0; ph < 2; ph++) begin
      write_reg(REG_START_X, $urandom);
      write_reg(REG_START_Y, $urandom);
      write_reg(REG_START_H, $urandom);
      add_random(350);
      drain();
    end

    $display("%0d ticks sent, %0d poses checked over six start settings", n_ticks, n_poses);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

### planar_odometry_integrator_top.f
rtl/poi_pkg.sv
rtl/poi_if.sv
rtl/poi_cordic.sv
rtl/planar_odometry_integrator_top.sv
rtl/poi_checker.sv
sim/tb_top.sv
